// ----- design/rbs_pkg.sv -----
// Shared types, constants and saturation helpers for the ray/box slab test.
`timescale 1ns / 1ps
package rbs_pkg;

    localparam int COORD_W  = 32;
    localparam int FRAC     = 16;
    localparam int FACE_W   = COORD_W + 3;
    localparam int PROD_W   = FACE_W + COORD_W;
    localparam int PT_W     = 2 * COORD_W;
    localparam int QUO_W    = 2 * FRAC + 1;
    localparam int CNT_W    = $clog2(QUO_W + 1);
    localparam int LEN_W    = COORD_W - 1;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);

    localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Register indexes of the configuration port
    localparam logic [2:0] REG_ORG_X = 3'd0;
    localparam logic [2:0] REG_ORG_Y = 3'd1;
    localparam logic [2:0] REG_ORG_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X = 3'd3;
    localparam logic [2:0] REG_DIR_Y = 3'd4;
    localparam logic [2:0] REG_DIR_Z = 3'd5;
    localparam logic [2:0] REG_MAXLEN = 3'd6;

    typedef enum logic [1:0] {
        RCP_IDLE,
        RCP_RUN,
        RCP_DONE
    } rcp_state_t;

    typedef logic signed [FACE_W-1:0] face_t;

    typedef struct packed {
        face_t [2:0] pos;
        face_t [2:0] neg;
    } box_face_t;

    typedef struct packed {
        logic                      valid;
        logic [1:0]                axis;
        logic signed [COORD_W-1:0] value;
    } rcp_result_t;

    // Floor shift of a slab product and saturation to the coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_slab(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        begin
            s = p >>> FRAC;
            if ((&s[PROD_W-1:COORD_W-1]) || !(|s[PROD_W-1:COORD_W-1]))
                sat_slab = s[COORD_W-1:0];
            else
                sat_slab = s[PROD_W-1] ? CMIN : CMAX;
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_point(input logic signed [PT_W-1:0] p);
        logic signed [PT_W-1:0] s;
        begin
            s = p >>> FRAC;
            if ((&s[PT_W-1:COORD_W-1]) || !(|s[PT_W-1:COORD_W-1]))
                sat_point = s[COORD_W-1:0];
            else
                sat_point = s[PT_W-1] ? CMIN : CMAX;
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_sum(input logic signed [COORD_W:0] v);
        begin
            if (v[COORD_W] == v[COORD_W-1])
                sat_sum = v[COORD_W-1:0];
            else
                sat_sum = v[COORD_W] ? CMIN : CMAX;
        end
    endfunction

endpackage

// ----- design/ray_box_slab_intersect.sv -----
// Top level of the ray versus axis-aligned box slab test.
//
// One ray is held in seven configuration registers written over the cfg
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data). Boxes arrive on the
// input channel as centre and half extents; a transfer takes place when
// in_valid is high and in_stall low. Each box yields one result on the output
// channel, transferred when out_valid is high and out_stall low.
// One box per cycle is taken while in_stall is low. A taken box is written
// into the four-entry queue at its transfer edge, then passes four back
// stages (slab products, entry/exit selection, hit point product,
// saturating add) to the output. When out_stall is high the back stages
// hold, the queue fills and in_stall rises once it is full. Each write to a
// direction register starts the bit-serial reciprocal unit, which holds
// in_stall high and cfg_ready low while it works out 33 quotient bits, one
// per cycle, and then hands the result over in its done state. Reset loads
// the reciprocals of the reset direction at once, so boxes are accepted
// from the first cycle after reset.
`timescale 1ns / 1ps
module ray_box_slab_intersect
    import rbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [COORD_W-1:0]        cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] box_center_x,
    input  logic signed [COORD_W-1:0] box_center_y,
    input  logic signed [COORD_W-1:0] box_center_z,
    input  logic [LEN_W-1:0]          box_half_x,
    input  logic [LEN_W-1:0]          box_half_y,
    input  logic [LEN_W-1:0]          box_half_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      hit,
    output logic signed [COORD_W-1:0] hit_distance,
    output logic signed [COORD_W-1:0] hit_point_x,
    output logic signed [COORD_W-1:0] hit_point_y,
    output logic signed [COORD_W-1:0] hit_point_z
);

    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [COORD_W-1:0] dir_reg [3];
    logic signed [COORD_W-1:0] inv_reg [3];
    logic [LEN_W-1:0]          len_reg;
    logic                      cfg_wr, dir_wr, rcp_busy;
    logic [1:0]                dir_axis;
    rcp_result_t               rcp;
    logic                      accept, push, pop, q_empty, q_full;
    box_face_t                 faces, head;

    assign cfg_ready = !rcp_busy;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign dir_wr    = cfg_wr && (cfg_index == REG_DIR_X || cfg_index == REG_DIR_Y
                                  || cfg_index == REG_DIR_Z);
    assign dir_axis  = 2'(cfg_index - REG_DIR_X);
    assign in_stall  = q_full || rcp_busy;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= COORD_W'(1) <<< FRAC;
            dir_reg[1] <= '0;
            dir_reg[2] <= '0;
            inv_reg[0] <= COORD_W'(1) <<< FRAC;
            inv_reg[1] <= CMAX;
            inv_reg[2] <= CMAX;
            len_reg    <= '1;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_ORG_X:  org_reg[0] <= cfg_data;
                    REG_ORG_Y:  org_reg[1] <= cfg_data;
                    REG_ORG_Z:  org_reg[2] <= cfg_data;
                    REG_DIR_X:  dir_reg[0] <= cfg_data;
                    REG_DIR_Y:  dir_reg[1] <= cfg_data;
                    REG_DIR_Z:  dir_reg[2] <= cfg_data;
                    REG_MAXLEN: len_reg    <= cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (rcp.valid)
                inv_reg[rcp.axis] <= rcp.value;
        end
    end

    rbs_recip u_recip (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (dir_wr),
        .start_axis (dir_axis),
        .divisor    (cfg_data),
        .busy       (rcp_busy),
        .result     (rcp)
    );

    rbs_front u_front (
        .accept       (accept),
        .org_x        (org_reg[0]),
        .org_y        (org_reg[1]),
        .org_z        (org_reg[2]),
        .box_center_x (box_center_x),
        .box_center_y (box_center_y),
        .box_center_z (box_center_z),
        .box_half_x   (box_half_x),
        .box_half_y   (box_half_y),
        .box_half_z   (box_half_z),
        .push         (push),
        .faces        (faces)
    );

    rbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (faces),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    rbs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (head),
        .q_pop        (pop),
        .inv          (inv_reg),
        .org          (org_reg),
        .dir          (dir_reg),
        .max_len      (len_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .hit_distance (hit_distance),
        .hit_point_x  (hit_point_x),
        .hit_point_y  (hit_point_y),
        .hit_point_z  (hit_point_z)
    );

endmodule

// ----- design/rbs_recip.sv -----
// Bit-serial reciprocal unit: 2^(2*FRAC) / d, truncated and saturated.
`timescale 1ns / 1ps
module rbs_recip
    import rbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                start_axis,
    input  logic signed [COORD_W-1:0] divisor,
    output logic                      busy,
    output rcp_result_t               result
);

    rcp_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [COORD_W:0]        rem_reg, rem_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;
    logic [COORD_W-1:0]      den_reg, den_next;
    logic                    neg_reg, neg_next;
    logic [1:0]              axis_reg, axis_next;
    logic [COORD_W+1:0]      trial;
    logic [COORD_W:0]        shifted;

    // Dividend is a single one at bit QUO_W-1, so only the first step brings in a one.
    assign shifted = {rem_reg[COORD_W-1:0], (cnt_reg == CNT_W'(QUO_W - 1))};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            RCP_IDLE: if (start) state_next = RCP_RUN;
            RCP_RUN:  if (cnt_reg == '0) state_next = RCP_DONE;
            RCP_DONE: state_next = RCP_IDLE;
            default:  state_next = RCP_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        axis_next = axis_reg;
        case (state_reg)
            RCP_IDLE:
            begin
                if (start)
                begin
                    cnt_next  = CNT_W'(QUO_W - 1);
                    rem_next  = '0;
                    quo_next  = '0;
                    den_next  = divisor[COORD_W-1] ? COORD_W'(-divisor) : COORD_W'(divisor);
                    neg_next  = divisor[COORD_W-1];
                    axis_next = start_axis;
                end
            end
            RCP_RUN:
            begin
                if (!trial[COORD_W+1])
                begin
                    rem_next = trial[COORD_W:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RCP_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        axis_reg <= axis_next;
    end

    // A zero divisor yields an all-ones quotient and so saturates to the maximum.
    always_comb
    begin
        busy         = (state_reg != RCP_IDLE);
        result.valid = (state_reg == RCP_DONE);
        result.axis  = axis_reg;
        if (quo_reg[QUO_W-1:COORD_W-1] != '0)
            result.value = neg_reg ? CMIN : CMAX;
        else if (neg_reg)
            result.value = -$signed({1'b0, quo_reg[COORD_W-2:0]});
        else
            result.value = $signed({1'b0, quo_reg[COORD_W-2:0]});
    end

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RCP_DONE) |-> $past(state_reg == RCP_RUN))
        else $error("reciprocal finished without running");
    a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RCP_RUN && $past(state_reg == RCP_IDLE)) |-> $past(start))
        else $error("reciprocal ran without a start");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> busy)
        else $error("result shown while idle");

endmodule

// ----- design/rbs_queue.sv -----
// Short queue of box face offsets between the front and back parts.
`timescale 1ns / 1ps
module rbs_queue
    import rbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  box_face_t push_data,
    input  logic      pop,
    output box_face_t head,
    output logic      empty,
    output logic      full
);

    box_face_t         mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_reg, wr_next;
    logic [Q_AW-1:0]   rd_reg, rd_next;
    logic [Q_AW:0]     cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign head  = mem[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + Q_AW'(1) : wr_reg;
        rd_next  = pop ? rd_reg + Q_AW'(1) : rd_reg;
        cnt_next = cnt_reg + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- design/rbs_front.sv -----
// Front part: accepts boxes and forms the face offsets from the ray origin.
`timescale 1ns / 1ps
module rbs_front
    import rbs_pkg::*;
(
    input  logic                      accept,
    input  logic signed [COORD_W-1:0] org_x,
    input  logic signed [COORD_W-1:0] org_y,
    input  logic signed [COORD_W-1:0] org_z,
    input  logic signed [COORD_W-1:0] box_center_x,
    input  logic signed [COORD_W-1:0] box_center_y,
    input  logic signed [COORD_W-1:0] box_center_z,
    input  logic [LEN_W-1:0]          box_half_x,
    input  logic [LEN_W-1:0]          box_half_y,
    input  logic [LEN_W-1:0]          box_half_z,
    output logic                      push,
    output box_face_t                 faces
);

    logic signed [COORD_W-1:0] c [3];
    logic signed [COORD_W-1:0] o [3];
    logic [LEN_W-1:0]          h [3];
    face_t                     cw, ow, hw;

    assign c[0] = box_center_x;
    assign c[1] = box_center_y;
    assign c[2] = box_center_z;
    assign o[0] = org_x;
    assign o[1] = org_y;
    assign o[2] = org_z;
    assign h[0] = box_half_x;
    assign h[1] = box_half_y;
    assign h[2] = box_half_z;
    assign push = accept;

    // Offsets are kept exact: three guard bits cover centre plus half minus origin.
    always_comb
    begin
        cw = '0;
        ow = '0;
        hw = '0;
        for (int k = 0; k < 3; k++)
        begin
            cw = FACE_W'(c[k]);
            ow = FACE_W'(o[k]);
            hw = $signed({{(FACE_W-LEN_W){1'b0}}, h[k]});
            faces.pos[k] = cw + hw - ow;
            faces.neg[k] = cw - hw - ow;
        end
    end

endmodule

// ----- design/rbs_back.sv -----
// Back part: slab products, entry and exit selection, hit test and hit point.
`timescale 1ns / 1ps
module rbs_back
    import rbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  box_face_t                 q_head,
    output logic                      q_pop,
    input  logic signed [COORD_W-1:0] inv [3],
    input  logic signed [COORD_W-1:0] org [3],
    input  logic signed [COORD_W-1:0] dir [3],
    input  logic [LEN_W-1:0]          max_len,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      hit,
    output logic signed [COORD_W-1:0] hit_distance,
    output logic signed [COORD_W-1:0] hit_point_x,
    output logic signed [COORD_W-1:0] hit_point_y,
    output logic signed [COORD_W-1:0] hit_point_z
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic signed [PROD_W-1:0]  pa_reg [3];
    logic signed [PROD_W-1:0]  pb_reg [3];
    logic                      hit2_reg, hit3_reg;
    logic signed [COORD_W-1:0] tn2_reg, tn3_reg;
    logic signed [PT_W-1:0]    pp3_reg [3];
    logic signed [COORD_W-1:0] ta, tb, lo, hi, tnear, tfar;
    logic                      hit_c;
    logic signed [COORD_W-1:0] pt_c [3];

    assign en4   = !v4_reg || !out_stall;
    assign en3   = !v3_reg || en4;
    assign en2   = !v2_reg || en3;
    assign en1   = !v1_reg || en2;
    assign q_pop = en1 && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= !q_empty;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Entry is the largest per-axis minimum, exit the smallest per-axis maximum.
    always_comb
    begin
        tnear = CMIN;
        tfar  = CMAX;
        ta    = '0;
        tb    = '0;
        lo    = '0;
        hi    = '0;
        for (int k = 0; k < 3; k++)
        begin
            ta = sat_slab(pa_reg[k]);
            tb = sat_slab(pb_reg[k]);
            lo = (ta < tb) ? ta : tb;
            hi = (ta < tb) ? tb : ta;
            if (lo > tnear) tnear = lo;
            if (hi < tfar)  tfar  = hi;
        end
        hit_c = !(tfar < 0) && !(tnear > tfar)
                && !(tnear > $signed({1'b0, max_len}));
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            pt_c[k] = sat_sum(COORD_W'(org[k]) + (COORD_W+1)'(sat_point(pp3_reg[k])));
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pa_reg[k] <= $signed(q_head.pos[k]) * inv[k];
                pb_reg[k] <= $signed(q_head.neg[k]) * inv[k];
            end
        end
        if (en2)
        begin
            hit2_reg <= hit_c;
            tn2_reg  <= tnear;
        end
        if (en3)
        begin
            hit3_reg <= hit2_reg;
            tn3_reg  <= tn2_reg;
            for (int k = 0; k < 3; k++)
                pp3_reg[k] <= dir[k] * tn2_reg;
        end
        if (en4)
        begin
            hit          <= hit3_reg;
            hit_distance <= hit3_reg ? tn3_reg : '0;
            hit_point_x  <= hit3_reg ? pt_c[0] : '0;
            hit_point_y  <= hit3_reg ? pt_c[1] : '0;
            hit_point_z  <= hit3_reg ? pt_c[2] : '0;
        end
    end

    assign out_valid = v4_reg;

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (hit_distance == '0 && hit_point_x == '0
                                  && hit_point_y == '0 && hit_point_z == '0))
        else $error("miss with non-zero payload");
    a_hit_in_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> !(hit_distance > $signed({1'b0, max_len})))
        else $error("hit beyond ray length");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> v1_reg)
        else $error("popped item lost at first stage");

endmodule
